// ===== sv/ssi_pkg.sv =====
// Shared constants and types for the satin stitch interpolator.
// No dependencies.
package ssi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int FAR_BITS    = 24;
    localparam int SQ_SHIFT    = 14;
    localparam int SQRT_STEPS  = 32;
    localparam int LEN_SHIFT   = 11;
    localparam int LEN_DIV     = 25;
    localparam int DIV_REM_BITS = 5;
    localparam logic [15:0] DENSITY_RESET = 16'd200;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/ssi_queue.sv =====
// Two-entry item queue between the front and back parts.
// Depends on ssi_pkg.
module ssi_queue #(
    parameter int WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output ssi_pkg::q_status_t status
);

    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");

endmodule

// ===== sv/ssi_front.sv =====
// Front part: accepts a segment, computes step count and per-edge steps.
// Depends on ssi_pkg.
module ssi_front #(
    parameter int MAX_STEPS  = 31,
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] top_start_x,
    input  logic signed [COORD_BITS-1:0] top_start_y,
    input  logic signed [COORD_BITS-1:0] top_end_x,
    input  logic signed [COORD_BITS-1:0] top_end_y,
    input  logic signed [COORD_BITS-1:0] bottom_start_x,
    input  logic signed [COORD_BITS-1:0] bottom_start_y,
    input  logic signed [COORD_BITS-1:0] bottom_end_x,
    input  logic signed [COORD_BITS-1:0] bottom_end_y,
    input  logic                         final_segment,
    input  logic [15:0]                  density,
    input  ssi_pkg::q_status_t           q_status,
    output logic                         push,
    output logic [8*COORD_BITS+4*(COORD_BITS+17)+$clog2(MAX_STEPS+1)+1:0] push_data
);

    localparam int C   = COORD_BITS;
    localparam int NW  = $clog2(MAX_STEPS + 1);
    localparam int SW  = C + 17;
    localparam int DW  = C + ssi_pkg::FRAC_BITS;
    localparam int CW  = $clog2(DW + 1);
    localparam int QB  = NW + ssi_pkg::DIV_REM_BITS;
    localparam int THR = ssi_pkg::LEN_DIV * (MAX_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MAG, S_SQR, S_SINIT, S_SQRT, S_SCALE, S_NDIV, S_STEP, S_PUSH
    } state_t;

    state_t                state_reg;
    logic signed [C-1:0]   crd_reg [0:7];
    logic                  final_reg;
    logic [23:0]           ax_reg;
    logic [23:0]           ay_reg;
    logic                  far_reg;
    logic [47:0]           sqx_reg;
    logic [47:0]           sqy_reg;
    logic [63:0]           v_reg;
    logic [63:0]           root_reg;
    logic [63:0]           bit_reg;
    logic [47:0]           prod_reg;
    logic [NW-1:0]         n_reg;
    logic                  clip_reg;
    logic [DW-1:0]         dvd_reg [0:3];
    logic [NW-1:0]         rem_reg [0:3];
    logic                  neg_reg [0:3];
    logic [CW-1:0]         cnt_reg;

    logic signed [C+1:0]   dx2;
    logic signed [C+1:0]   dy2;
    logic [C+1:0]          ax;
    logic [C+1:0]          ay;
    logic [63:0]           trial;
    logic [36:0]           q;
    logic [NW-1:0]         n_small;
    logic signed [C:0]     delta [0:3];
    logic signed [SW-1:0]  step [0:3];

    function automatic logic [NW-1:0] div25(input logic [QB-1:0] qv);
        logic [ssi_pkg::DIV_REM_BITS:0] r;
        logic [NW-1:0] res;
        r   = {1'b0, qv[QB-1:NW]};
        res = '0;
        for (int k = NW - 1; k >= 0; k--)
        begin
            r = {r[ssi_pkg::DIV_REM_BITS-1:0], qv[k]};
            if (r >= (ssi_pkg::DIV_REM_BITS+1)'(ssi_pkg::LEN_DIV))
            begin
                r      = r - (ssi_pkg::DIV_REM_BITS+1)'(ssi_pkg::LEN_DIV);
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

    assign busy = (state_reg != S_IDLE);

    assign dx2 = (C+2)'(crd_reg[0]) + (C+2)'(crd_reg[4]) - (C+2)'(crd_reg[2])
               - (C+2)'(crd_reg[6]);
    assign dy2 = (C+2)'(crd_reg[1]) + (C+2)'(crd_reg[5]) - (C+2)'(crd_reg[3])
               - (C+2)'(crd_reg[7]);
    assign ax  = dx2[C+1] ? (C+2)'(-dx2) : (C+2)'(dx2);
    assign ay  = dy2[C+1] ? (C+2)'(-dy2) : (C+2)'(dy2);
    assign trial = root_reg + bit_reg;
    assign q       = 37'(prod_reg >> ssi_pkg::LEN_SHIFT);
    assign n_small = div25(QB'(q));

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            delta[k] = (C+1)'(crd_reg[(k / 2) * 4 + 2 + (k % 2)])
                     - (C+1)'(crd_reg[(k / 2) * 4 + (k % 2)]);
            step[k]  = neg_reg[k] ? -SW'(dvd_reg[k]) : SW'(dvd_reg[k]);
        end
    end

    assign push = (state_reg == S_PUSH) && !q_status.full;
    assign push_data = {crd_reg[0], crd_reg[1], crd_reg[4], crd_reg[5],
                        crd_reg[2], crd_reg[3], crd_reg[6], crd_reg[7],
                        step[0], step[1], step[2], step[3],
                        n_reg, clip_reg, final_reg};

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                crd_reg[0] <= top_start_x;
                crd_reg[1] <= top_start_y;
                crd_reg[2] <= top_end_x;
                crd_reg[3] <= top_end_y;
                crd_reg[4] <= bottom_start_x;
                crd_reg[5] <= bottom_start_y;
                crd_reg[6] <= bottom_end_x;
                crd_reg[7] <= bottom_end_y;
                final_reg  <= final_segment;
            end
            S_MAG:
            begin
                ax_reg  <= 24'(ax);
                ay_reg  <= 24'(ay);
                far_reg <= ((ax >> ssi_pkg::FAR_BITS) != '0)
                        || ((ay >> ssi_pkg::FAR_BITS) != '0);
            end
            S_SQR:
            begin
                sqx_reg <= ax_reg * ax_reg;
                sqy_reg <= ay_reg * ay_reg;
            end
            S_SINIT:
            begin
                v_reg    <= 64'({1'b0, sqx_reg} + {1'b0, sqy_reg}) << ssi_pkg::SQ_SHIFT;
                root_reg <= '0;
                bit_reg  <= 64'(1) << 62;
            end
            S_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg    <= v_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_SCALE:
            begin
                prod_reg <= root_reg[31:0] * density;
            end
            S_NDIV:
            begin
                if ((far_reg && density != '0) || q >= 37'(THR))
                begin
                    n_reg    <= NW'(MAX_STEPS);
                    clip_reg <= 1'b1;
                end
                else
                begin
                    n_reg    <= n_small;
                    clip_reg <= 1'b0;
                end
                for (int k = 0; k < 4; k++)
                begin
                    neg_reg[k] <= delta[k][C];
                    dvd_reg[k] <= DW'(delta[k][C] ? C'(-delta[k]) : C'(delta[k]))
                                  << ssi_pkg::FRAC_BITS;
                    rem_reg[k] <= '0;
                end
            end
            S_STEP:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if ({rem_reg[k], dvd_reg[k][DW-1]} >= {1'b0, n_reg})
                    begin
                        rem_reg[k] <= NW'({rem_reg[k], dvd_reg[k][DW-1]} - {1'b0, n_reg});
                        dvd_reg[k] <= {dvd_reg[k][DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= NW'({rem_reg[k], dvd_reg[k][DW-1]});
                        dvd_reg[k] <= {dvd_reg[k][DW-2:0], 1'b0};
                    end
                end
            end
            S_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:   state_reg <= S_SQR;
                S_SQR:   state_reg <= S_SINIT;
                S_SINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(ssi_pkg::SQRT_STEPS - 1))
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: state_reg <= S_NDIV;
                S_NDIV:
                begin
                    cnt_reg <= '0;
                    if (!((far_reg && density != '0) || q >= 37'(THR)) && n_small == '0)
                    begin
                        state_reg <= final_reg ? S_PUSH : S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(DW - 1))
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (!q_status.full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_push_only_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> state_reg == S_PUSH)
        else $error("push outside push state");
    a_clip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && clip_reg) |-> n_reg == NW'(MAX_STEPS))
        else $error("clipped item without saturated count");
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (n_reg != '0 || final_reg))
        else $error("empty item pushed");

endmodule

// ===== sv/ssi_back.sv =====
// Back part: walks the queued segment and emits the stitch points.
// Depends on ssi_pkg.
module ssi_back #(
    parameter int MAX_STEPS  = 31,
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssi_pkg::q_status_t           q_status,
    output logic                         pop,
    input  logic [8*COORD_BITS+4*(COORD_BITS+17)+$clog2(MAX_STEPS+1)+1:0] pop_data,
    output logic                         point_valid,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         on_top_edge,
    output logic                         steps_clipped,
    output logic                         end_of_run
);

    localparam int C  = COORD_BITS;
    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int SW = C + 17;
    localparam int AW = C + 18;
    localparam int FB = ssi_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        B_IDLE, B_TOP, B_BOT, B_FTOP, B_FBOT
    } state_t;

    state_t               state_reg;
    logic signed [C-1:0]  ts_x, ts_y, bs_x, bs_y, te_x, te_y, be_x, be_y;
    logic signed [SW-1:0] st_tx, st_ty, st_bx, st_by;
    logic [NW-1:0]        n_in;
    logic                 clip_in;
    logic                 final_in;

    logic signed [C-1:0]  fin_reg [0:3];
    logic signed [SW-1:0] stp_reg [0:3];
    logic signed [AW-1:0] acc_reg [0:3];
    logic [NW-1:0]        n_reg;
    logic [NW-1:0]        i_reg;
    logic                 clip_reg;
    logic                 final_reg;
    logic                 last_pair;

    assign {ts_x, ts_y, bs_x, bs_y, te_x, te_y, be_x, be_y,
            st_tx, st_ty, st_bx, st_by, n_in, clip_in, final_in} = pop_data;

    assign pop       = (state_reg == B_IDLE) && !q_status.empty;
    assign last_pair = (i_reg == n_reg - NW'(1));

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                acc_reg[0] <= AW'(ts_x) <<< FB;
                acc_reg[1] <= AW'(ts_y) <<< FB;
                acc_reg[2] <= AW'(bs_x) <<< FB;
                acc_reg[3] <= AW'(bs_y) <<< FB;
                stp_reg[0] <= st_tx;
                stp_reg[1] <= st_ty;
                stp_reg[2] <= st_bx;
                stp_reg[3] <= st_by;
                fin_reg[0] <= (n_in != '0) ? te_x : ts_x;
                fin_reg[1] <= (n_in != '0) ? te_y : ts_y;
                fin_reg[2] <= (n_in != '0) ? be_x : bs_x;
                fin_reg[3] <= (n_in != '0) ? be_y : bs_y;
                n_reg      <= n_in;
                clip_reg   <= clip_in;
                final_reg  <= final_in;
                i_reg      <= '0;
            end
            B_TOP:
            begin
                point_x    <= C'(acc_reg[0] >>> FB);
                point_y    <= C'(acc_reg[1] >>> FB);
                acc_reg[0] <= acc_reg[0] + AW'(stp_reg[0]);
                acc_reg[1] <= acc_reg[1] + AW'(stp_reg[1]);
            end
            B_BOT:
            begin
                point_x    <= C'(acc_reg[2] >>> FB);
                point_y    <= C'(acc_reg[3] >>> FB);
                acc_reg[2] <= acc_reg[2] + AW'(stp_reg[2]);
                acc_reg[3] <= acc_reg[3] + AW'(stp_reg[3]);
                i_reg      <= i_reg + NW'(1);
            end
            B_FTOP:
            begin
                point_x <= fin_reg[0];
                point_y <= fin_reg[1];
            end
            B_FBOT:
            begin
                point_x <= fin_reg[2];
                point_y <= fin_reg[3];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            point_valid   <= 1'b0;
            on_top_edge   <= 1'b0;
            steps_clipped <= 1'b0;
            end_of_run    <= 1'b0;
        end
        else
        begin
            point_valid   <= (state_reg != B_IDLE);
            on_top_edge   <= (state_reg == B_TOP) || (state_reg == B_FTOP);
            steps_clipped <= clip_reg;
            end_of_run    <= (state_reg == B_FBOT)
                          || (state_reg == B_BOT && last_pair && !final_reg);
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        state_reg <= (n_in != '0) ? B_TOP : B_FTOP;
                    end
                end
                B_TOP: state_reg <= B_BOT;
                B_BOT:
                begin
                    if (last_pair)
                    begin
                        state_reg <= final_reg ? B_FTOP : B_IDLE;
                    end
                    else
                    begin
                        state_reg <= B_TOP;
                    end
                end
                B_FTOP: state_reg <= B_FBOT;
                B_FBOT: state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_end_follows_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_run |-> (point_valid && !on_top_edge))
        else $error("end of run on a non-bottom point");
    a_top_then_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && on_top_edge) |=> (point_valid && !on_top_edge))
        else $error("top point not followed by bottom point");
    a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_BOT) |-> (i_reg < n_reg))
        else $error("pair index past step count");

endmodule

// ===== sv/satin_stitch_interpolator.sv =====
// Top level of the satin stitch interpolator: front, queue and back parts.
// Depends on ssi_pkg, ssi_front, ssi_queue, ssi_back.
//
// Usage: drive a segment on the corner ports with start high; it is taken
// at a clock edge where start is high and busy is low. busy stays high from
// that edge through the magnitude, square, 32-step square root, scale and
// saturate steps, the bit-serial step divider and the push, and longer
// while the two-entry queue to the back part is full. A segment with zero
// steps skips the divider, and skips the push as well unless it is final.
// The first point of a segment goes out once its item has passed the queue
// and the back part is free.
// The back part emits one point per cycle on point_x/point_y with
// point_valid high for that single cycle: 2*N points, then two final
// points on a final segment, passing through its idle state between
// segments. The front works on the next segment while points of earlier
// ones go out. Segments with zero steps that are not final emit nothing.
// Results cannot be stalled by the receiver.
// The density register is written through cfg_valid/cfg_data; cfg_ready is
// always high. Reset sets the density to 200 and empties the queue.
module satin_stitch_interpolator #(
    parameter int MAX_STEPS  = 31,
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] top_start_x,
    input  logic signed [COORD_BITS-1:0] top_start_y,
    input  logic signed [COORD_BITS-1:0] top_end_x,
    input  logic signed [COORD_BITS-1:0] top_end_y,
    input  logic signed [COORD_BITS-1:0] bottom_start_x,
    input  logic signed [COORD_BITS-1:0] bottom_start_y,
    input  logic signed [COORD_BITS-1:0] bottom_end_x,
    input  logic signed [COORD_BITS-1:0] bottom_end_y,
    input  logic                         final_segment,
    output logic                         point_valid,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         on_top_edge,
    output logic                         steps_clipped,
    output logic                         end_of_run,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [15:0]                  cfg_data
);

    localparam int EW = 8*COORD_BITS + 4*(COORD_BITS+17) + $clog2(MAX_STEPS+1) + 2;

    logic [15:0]        density_reg;
    logic               q_push;
    logic               q_pop;
    logic [EW-1:0]      q_in;
    logic [EW-1:0]      q_out;
    ssi_pkg::q_status_t q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= ssi_pkg::DENSITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            density_reg <= cfg_data;
        end
    end

    ssi_front #(
        .MAX_STEPS  (MAX_STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .top_start_x    (top_start_x),
        .top_start_y    (top_start_y),
        .top_end_x      (top_end_x),
        .top_end_y      (top_end_y),
        .bottom_start_x (bottom_start_x),
        .bottom_start_y (bottom_start_y),
        .bottom_end_x   (bottom_end_x),
        .bottom_end_y   (bottom_end_y),
        .final_segment  (final_segment),
        .density        (density_reg),
        .q_status       (q_status),
        .push           (q_push),
        .push_data      (q_in)
    );

    ssi_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    ssi_back #(
        .MAX_STEPS  (MAX_STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop           (q_pop),
        .pop_data      (q_out),
        .point_valid   (point_valid),
        .point_x       (point_x),
        .point_y       (point_y),
        .on_top_edge   (on_top_edge),
        .steps_clipped (steps_clipped),
        .end_of_run    (end_of_run)
    );

endmodule

// ===== dv/satin_stitch_interpolator_test.sv =====
// Self-checking testbench for satin_stitch_interpolator: directed and random segments,
// random start gaps, several density settings; every point checked against a predictor.
// Depends on ssi_pkg and the satin_stitch_interpolator RTL.
`timescale 1ns / 100ps

module satin_stitch_interpolator_test;

    localparam int MAX_STEPS  = 31;
    localparam int COORD_BITS = 20;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t tsx, tsy, tex, tey;
        coord_t bsx, bsy, bex, bey;
        logic   fin;
    } segment_t;

    typedef struct {
        coord_t x, y;
        logic   top, clip, last;
    } stitch_t;

    logic clk, rst_n, start, busy;
    coord_t top_start_x, top_start_y, top_end_x, top_end_y;
    coord_t bottom_start_x, bottom_start_y, bottom_end_x, bottom_end_y;
    logic final_segment;
    logic point_valid, on_top_edge, steps_clipped, end_of_run;
    coord_t point_x, point_y;
    logic cfg_valid, cfg_ready;
    logic [15:0] cfg_data;

    segment_t pending_segs[$];
    stitch_t  expected_stitches[$];
    logic [15:0] density;
    int errors;
    bit quiet, hold;
    longint cycles;

    satin_stitch_interpolator #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .top_start_x(top_start_x), .top_start_y(top_start_y),
        .top_end_x(top_end_x), .top_end_y(top_end_y),
        .bottom_start_x(bottom_start_x), .bottom_start_y(bottom_start_y),
        .bottom_end_x(bottom_end_x), .bottom_end_y(bottom_end_y),
        .final_segment(final_segment),
        .point_valid(point_valid), .point_x(point_x), .point_y(point_y),
        .on_top_edge(on_top_edge), .steps_clipped(steps_clipped), .end_of_run(end_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic stitch_t make_stitch(longint fx, longint fy, logic top, logic clip,
                                            logic last);
        stitch_t s;
        s.x = coord_t'(fx >>> 16);
        s.y = coord_t'(fy >>> 16);
        s.top = top;
        s.clip = clip;
        s.last = last;
        return s;
    endfunction

    task automatic predict_stitches(segment_t g);
        longint tsx, tsy, tex, tey, bsx, bsy, bex, bey, dx2, dy2, tstx, tsty, bstx, bsty;
        longint unsigned ax, ay, n, len;
        logic clip;
        int total, k;
        tsx = g.tsx; tsy = g.tsy; tex = g.tex; tey = g.tey;
        bsx = g.bsx; bsy = g.bsy; bex = g.bex; bey = g.bey;
        dx2 = (tsx + bsx) - (tex + bex);
        dy2 = (tsy + bsy) - (tey + bey);
        ax = dx2 < 0 ? -dx2 : dx2;
        ay = dy2 < 0 ? -dy2 : dy2;
        n = 0;
        clip = 1'b0;
        k = 0;
        if (density != 0)
        begin
            if (ax >= (64'd1 << 24) || ay >= (64'd1 << 24))
                n = MAX_STEPS + 1;
            else
            begin
                len = int_sqrt((ax * ax + ay * ay) * 64'd16384);
                n = (len * density) / 64'd51200;
            end
        end
        if (n > MAX_STEPS)
        begin
            n = MAX_STEPS;
            clip = 1'b1;
        end
        tstx = 0; tsty = 0; bstx = 0; bsty = 0;
        if (n > 0)
        begin
            tstx = ((tex - tsx) * 65536) / longint'(n);
            tsty = ((tey - tsy) * 65536) / longint'(n);
            bstx = ((bex - bsx) * 65536) / longint'(n);
            bsty = ((bey - bsy) * 65536) / longint'(n);
        end
        total = int'(n) * 2 + (g.fin ? 2 : 0);
        for (int i = 0; i < int'(n); i++)
        begin
            expected_stitches.push_back(make_stitch(tsx * 65536 + i * tstx,
                tsy * 65536 + i * tsty, 1'b1, clip, k == total - 1));
            k++;
            expected_stitches.push_back(make_stitch(bsx * 65536 + i * bstx,
                bsy * 65536 + i * bsty, 1'b0, clip, k == total - 1));
            k++;
        end
        if (g.fin)
        begin
            if (n > 0)
            begin
                expected_stitches.push_back(make_stitch(tex * 65536, tey * 65536, 1'b1, clip, 1'b0));
                expected_stitches.push_back(make_stitch(bex * 65536, bey * 65536, 1'b0, clip, 1'b1));
            end
            else
            begin
                expected_stitches.push_back(make_stitch(tsx * 65536, tsy * 65536, 1'b1, clip, 1'b0));
                expected_stitches.push_back(make_stitch(bsx * 65536, bsy * 65536, 1'b0, clip, 1'b1));
            end
        end
    endtask

    // driver: offer the oldest pending segment, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                predict_stitches(pending_segs[0]);
                void'(pending_segs.pop_front());
            end
            if (pending_segs.size() > 0 && !hold && (quiet || $urandom_range(0, 99) >= 12))
            begin
                start <= 1'b1;
                top_start_x <= pending_segs[0].tsx;
                top_start_y <= pending_segs[0].tsy;
                top_end_x <= pending_segs[0].tex;
                top_end_y <= pending_segs[0].tey;
                bottom_start_x <= pending_segs[0].bsx;
                bottom_start_y <= pending_segs[0].bsy;
                bottom_end_x <= pending_segs[0].bex;
                bottom_end_y <= pending_segs[0].bey;
                final_segment <= pending_segs[0].fin;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each point with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && point_valid)
        begin
            if (expected_stitches.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d top=%0b", $time, point_x, point_y,
                         on_top_edge);
                errors++;
            end
            else
            begin
                stitch_t e;
                e = expected_stitches.pop_front();
                if (point_x !== e.x || point_y !== e.y || on_top_edge !== e.top ||
                    steps_clipped !== e.clip || end_of_run !== e.last)
                begin
                    $display("%0t: expected x=%0d y=%0d top=%0b clip=%0b last=%0b", $time,
                             e.x, e.y, e.top, e.clip, e.last);
                    $display("%0t: actual   x=%0d y=%0d top=%0b clip=%0b last=%0b", $time,
                             point_x, point_y, on_top_edge, steps_clipped, end_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("satin_stitch_interpolator_test failed");
            $finish;
        end
    end

    function automatic segment_t seg_of(longint tsx, longint tsy, longint tex, longint tey,
                                        longint bsx, longint bsy, longint bex, longint bey,
                                        logic fin);
        segment_t g;
        g.tsx = coord_t'(tsx); g.tsy = coord_t'(tsy); g.tex = coord_t'(tex); g.tey = coord_t'(tey);
        g.bsx = coord_t'(bsx); g.bsy = coord_t'(bsy); g.bex = coord_t'(bex); g.bey = coord_t'(bey);
        g.fin = fin;
        return g;
    endfunction

    function automatic segment_t random_segment();
        segment_t g;
        int cx, cy, w, lx, ly, span;
        if ($urandom_range(0, 9) == 0)
        begin
            g = seg_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom_range(0, 1));
            return g;
        end
        span = $urandom_range(0, 3) == 0 ? 40 : 400;
        cx = $urandom_range(0, 1040000) - 520000;
        cy = $urandom_range(0, 1040000) - 520000;
        w  = $urandom_range(0, 200) - 100;
        lx = $urandom_range(0, 2 * span) - span;
        ly = $urandom_range(0, 2 * span) - span;
        g = seg_of(cx + $urandom_range(0, 20), cy + w, cx + lx + $urandom_range(0, 20),
                   cy + ly + w + $urandom_range(0, 9), cx - $urandom_range(0, 20), cy - w,
                   cx + lx - $urandom_range(0, 20), cy + ly - w, $urandom_range(0, 3) == 0);
        return g;
    endfunction

    task automatic wait_idle();
        while (pending_segs.size() > 0 || start || expected_stitches.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_density(logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        density = d;
    endtask

    initial
    begin
        logic [15:0] settings[5];
        settings = '{16'd200, 16'd1, 16'd65535, 16'd137, 16'd400};
        errors = 0;
        cycles = 0;
        quiet = 0;
        hold = 0;
        density = ssi_pkg::DENSITY_RESET;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        {top_start_x, top_start_y, top_end_x, top_end_y} = '0;
        {bottom_start_x, bottom_start_y, bottom_end_x, bottom_end_y} = '0;
        final_segment = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_segs.push_back(seg_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        pending_segs.push_back(seg_of(5, 5, 5, 5, 7, 7, 7, 7, 1'b0));
        pending_segs.push_back(seg_of(0, 0, 100, 0, 0, 10, 100, 10, 1'b0));
        pending_segs.push_back(seg_of(0, 0, 100, 0, 0, 10, 100, 10, 1'b1));
        pending_segs.push_back(seg_of(-524288, -524288, 524287, 524287,
                                      -524288, -524288, 524287, 524287, 1'b1));
        pending_segs.push_back(seg_of(524287, 524287, -524288, -524288,
                                      524287, -524288, -524288, 524287, 1'b0));
        pending_segs.push_back(seg_of(524287, -524288, 524287, -524288,
                                      -524288, 524287, -524288, 524287, 1'b1));
        pending_segs.push_back(seg_of(-3, -7, 2, 5, 9, -1, -9, 4, 1'b1));
        pending_segs.push_back(seg_of(0, 0, 200, 0, 0, 0, 200, 0, 1'b1));
        pending_segs.push_back(seg_of(0, 0, -37, 61, 0, 0, -55, 29, 1'b0));
        pending_segs.push_back(seg_of(10, 10, 3000, -2000, 20, 40, 3100, -1900, 1'b1));
        pending_segs.push_back(seg_of(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1));
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            write_density(settings[p]);
            quiet = (p == 3);
            for (int i = 0; i < 70; i++)
                pending_segs.push_back(random_segment());
            while (pending_segs.size() > 35)
                @(posedge clk);
            hold = 1;
            while (expected_stitches.size() > 0)
                @(posedge clk);
            hold = 0;
            wait_idle();
        end

        if (errors == 0 && expected_stitches.size() == 0)
            $display("satin_stitch_interpolator_test passed");
        else
            $display("satin_stitch_interpolator_test failed");
        $finish;
    end
endmodule
